@@ src/rkc_pkg.sv @@
// Shared types, codes and constants for the RGB kernel convolution block.
package rkc_pkg;

  // Default store and kernel limits
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_KERNEL = 7;

  // Field widths
  localparam int COORD_W = 8;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int WGT_W   = 16;
  localparam int TAP_W   = 3;
  localparam int GAIN_W  = 24;
  localparam int DIM_W   = 9;
  localparam int KSZ_W   = 3;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 2;
  localparam int ACT_W   = 2;

  // Fraction bits of weight times gain (Q.12 * Q.16)
  localparam int Q_SHIFT = 28;

  // Sequencer counter and fixed phase lengths
  localparam int CNT_W     = 3;
  localparam int DRAIN_CYC = 2;
  localparam int NUM_CH    = 3;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PIXEL   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WEIGHT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_KSIZE  = 2'd2;
  localparam logic [IDX_W-1:0] REG_GAIN   = 2'd3;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 9'd256;
  localparam logic [KSZ_W-1:0]  RST_KSIZE  = 3'd3;
  localparam logic [GAIN_W-1:0] RST_GAIN   = 24'd65536;

  // Channel slots
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODX,
    ST_BACK,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_FLUSH,
    ST_RESULT
  } rkc_state_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic       clear;
    logic       issue;
    logic       scale;
    logic [1:0] ch;
  } mac_ctl_t;

endpackage

@@ src/rkc_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module rkc_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 8,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/rkc_ctrl.sv @@
// Sequencer: wrap setup, tap address walk and phase control.
module rkc_ctrl import rkc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int WW  = $clog2(MAX_WIDTH + 1),
  parameter int HW  = $clog2(MAX_HEIGHT + 1),
  parameter int KW  = $clog2(MAX_KERNEL + 1),
  parameter int PAW = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int WAW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] cmd_x,
  input  logic [COORD_W-1:0] cmd_y,
  input  logic [WW-1:0]      img_w,
  input  logic [HW-1:0]      img_h,
  input  logic [KW-1:0]      ksize,
  input  logic               res_take,
  output logic               busy,
  output logic               res_ready,
  output mac_ctl_t           mac_ctl,
  output logic [PAW-1:0]     pix_raddr,
  output logic [WAW-1:0]     wgt_raddr
);

  localparam int KI = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  rkc_state_t state, state_next;

  logic [CNT_W-1:0] cnt;
  logic [WW-1:0]    col, start_col;
  logic [HW-1:0]    row, start_row;
  logic [KI-1:0]    fx, fy;

  logic [CNT_W-1:0] ctr;
  logic [WW:0]      col_sh;
  logic [HW:0]      row_sh;
  logic [WW-1:0]    col_inc;
  logic [HW-1:0]    row_inc;
  logic             row_end, last_tap;

  assign ctr     = CNT_W'(ksize >> 1);
  assign col_sh  = {col, cmd_x[cnt]};
  assign row_sh  = {row, cmd_y[cnt]};
  assign col_inc = col + WW'(1);
  assign row_inc = row + HW'(1);
  assign row_end = (KW'(fx) + KW'(1)) == ksize;
  assign last_tap = row_end && ((KW'(fy) + KW'(1)) == ksize);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_MODX;
      ST_MODX:   if (cnt == '0) state_next = ST_BACK;
      ST_BACK:   if (cnt == '0) state_next = ST_MAC;
      ST_MAC:    if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN:  if (cnt == '0) state_next = ST_SCALE;
      ST_SCALE:  if (cnt == '0) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_RESULT;
      ST_RESULT: if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy          = (state != ST_IDLE);
    res_ready     = (state == ST_RESULT);
    mac_ctl.clear = (state == ST_IDLE);
    mac_ctl.issue = (state == ST_MAC);
    mac_ctl.scale = (state == ST_SCALE);
    mac_ctl.ch    = cnt[1:0];
    pix_raddr     = PAW'(row) * PAW'(MAX_WIDTH) + PAW'(col);
    wgt_raddr     = WAW'(fy) * WAW'(MAX_KERNEL) + WAW'(fx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        ST_IDLE:  cnt <= CNT_W'(COORD_W - 1);
        ST_MODX:  cnt <= (cnt == '0) ? ctr : cnt - CNT_W'(1);
        ST_MAC:   cnt <= CNT_W'(DRAIN_CYC - 1);
        ST_DRAIN: cnt <= (cnt == '0) ? CNT_W'(NUM_CH - 1) : cnt - CNT_W'(1);
        default:  cnt <= (cnt == '0) ? cnt : cnt - CNT_W'(1);
      endcase
    end
  end

  // Coordinate walk: remainder, center offset, then taps with wrap
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col <= '0;
        row <= '0;
        fx  <= '0;
        fy  <= '0;
      end
      ST_MODX: begin
        // one restoring remainder step per cycle
        col <= (col_sh >= {1'b0, img_w}) ? WW'(col_sh - {1'b0, img_w}) : col_sh[WW-1:0];
        row <= (row_sh >= {1'b0, img_h}) ? HW'(row_sh - {1'b0, img_h}) : row_sh[HW-1:0];
      end
      ST_BACK: begin
        if (cnt == '0) begin
          start_col <= col;
          start_row <= row;
        end else begin
          col <= (col == '0) ? img_w - WW'(1) : col - WW'(1);
          row <= (row == '0) ? img_h - HW'(1) : row - HW'(1);
        end
      end
      ST_MAC: begin
        if (row_end) begin
          fx  <= '0;
          fy  <= fy + KI'(1);
          col <= start_col;
          row <= (row_inc == img_h) ? '0 : row_inc;
        end else begin
          fx  <= fx + KI'(1);
          col <= (col_inc == img_w) ? '0 : col_inc;
        end
      end
      default: begin
        col <= col;
      end
    endcase
  end

endmodule

@@ src/rkc_mac.sv @@
// Datapath: per-channel multiply-accumulate, gain scaling and clamp.
module rkc_mac import rkc_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          ctl,
  input  logic [PIX_W-1:0]  pix,
  input  logic [WGT_W-1:0]  wgt,
  input  logic [GAIN_W-1:0] gain,
  output logic [CH_W-1:0]   res_red,
  output logic [CH_W-1:0]   res_green,
  output logic [CH_W-1:0]   res_blue
);

  localparam int PROD_W = CH_W + 1 + WGT_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int SP_W   = ACC_W + GAIN_W + 1;

  logic v1, v2, sv;
  logic [1:0] sch;
  logic signed [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic signed [ACC_W-1:0]  acc_r, acc_g, acc_b, acc_sel;
  logic signed [SP_W-1:0]   sprod;
  logic [CH_W-1:0]          clamped;

  // Tap pipeline valid: read data, then products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      sv <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      sv <= ctl.scale;
    end
  end

  // Products of pixel channel and signed weight
  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, pix[3*CH_W-1:2*CH_W]}) * $signed(wgt);
    prod_g <= $signed({1'b0, pix[2*CH_W-1:CH_W]}) * $signed(wgt);
    prod_b <= $signed({1'b0, pix[CH_W-1:0]}) * $signed(wgt);
  end

  // Accumulate
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (v2) begin
      acc_r <= acc_r + ACC_W'(prod_r);
      acc_g <= acc_g + ACC_W'(prod_g);
      acc_b <= acc_b + ACC_W'(prod_b);
    end
  end

  // One shared gain multiplier, one channel per cycle
  always_comb begin
    case (ctl.ch)
      CH_RED:   acc_sel = acc_r;
      CH_GREEN: acc_sel = acc_g;
      default:  acc_sel = acc_b;
    endcase
  end

  always_ff @(posedge clk) begin
    sprod <= SP_W'(acc_sel) * $signed({1'b0, gain});
    sch   <= ctl.ch;
  end

  // Non-positive gives zero; otherwise drop fraction and saturate
  always_comb begin
    if (sprod[SP_W-1] || sprod == '0) begin
      clamped = '0;
    end else if (sprod[SP_W-2:Q_SHIFT+CH_W] != '0) begin
      clamped = '1;
    end else begin
      clamped = sprod[Q_SHIFT+CH_W-1:Q_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      case (sch)
        CH_RED:   res_red   <= clamped;
        CH_GREEN: res_green <= clamped;
        default:  res_blue  <= clamped;
      endcase
    end
  end

endmodule

@@ src/rgb_kernel_convolution_wrap.sv @@
// Top level: RGB frame convolution with toroidal wrap over stored pixels.
//
//  channel | handshake         | carries
//  --------+-------------------+---------------------------------------------
//  in      | in_valid/in_stall | action, x/y, pixel, tap position and weight
//  out     | out_valid/out_stall | x/y and filtered red, green, blue
//  cfg     | cfg_write         | cfg_index, cfg_data
//
// A compute runs 8 remainder steps for the wrap origin, k/2+1 for the
// center offset, one pixel-memory read per tap, then drain, three gain
// multiplies and handoff. Reset clears control state only; both memories
// start undefined. in_stall is high from a compute's acceptance until its
// result enters the output register; a held result does not block the
// next item.
module rgb_kernel_convolution_wrap import rkc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ACT_W-1:0]   action,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic [CH_W-1:0]    red_in,
  input  logic [CH_W-1:0]    green_in,
  input  logic [CH_W-1:0]    blue_in,
  input  logic [TAP_W-1:0]   tap_col,
  input  logic [TAP_W-1:0]   tap_row,
  input  logic signed [WGT_W-1:0] tap_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic [CH_W-1:0]    out_red,
  output logic [CH_W-1:0]    out_green,
  output logic [CH_W-1:0]    out_blue,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int PDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PAW   = $clog2(PDEPTH);
  localparam int WDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int WAW   = (MAX_KERNEL > 1) ? $clog2(WDEPTH) : 1;

  logic [DIM_W-1:0]  image_width, image_height;
  logic [KSZ_W-1:0]  kernel_size;
  logic [GAIN_W-1:0] output_gain;

  logic [WW-1:0] img_w;
  logic [HW-1:0] img_h;
  logic [KW-1:0] ksize;

  logic [COORD_W-1:0] cmd_x, cmd_y;
  logic accept, start, busy, res_ready, res_take;
  logic pix_we, wgt_we;
  logic [PAW-1:0] pix_waddr, pix_raddr;
  logic [WAW-1:0] wgt_waddr, wgt_raddr;
  logic [PIX_W-1:0] pix_rdata;
  logic [WGT_W-1:0] wgt_rdata;
  logic [CH_W-1:0] res_red, res_green, res_blue;
  mac_ctl_t mac_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      kernel_size  <= RST_KSIZE;
      output_gain  <= RST_GAIN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_KSIZE:  kernel_size  <= cfg_data[KSZ_W-1:0];
        REG_GAIN:   output_gain  <= cfg_data[GAIN_W-1:0];
        default:    output_gain  <= output_gain;
      endcase
    end
  end

  // Saturate dimensions and kernel size into their legal ranges
  always_comb begin
    if (image_width == '0)                  img_w = WW'(1);
    else if (int'(image_width) > MAX_WIDTH) img_w = WW'(MAX_WIDTH);
    else                                    img_w = WW'(image_width);
    if (image_height == '0)                   img_h = HW'(1);
    else if (int'(image_height) > MAX_HEIGHT) img_h = HW'(MAX_HEIGHT);
    else                                      img_h = HW'(image_height);
    if (kernel_size == '0)                  ksize = KW'(1);
    else if (int'(kernel_size) > MAX_KERNEL) ksize = KW'(MAX_KERNEL);
    else                                    ksize = KW'(kernel_size);
  end

  // Input decode
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (action == ACT_COMPUTE);
  assign pix_we   = accept && (action == ACT_PIXEL) &&
                    (int'(x_coord) < MAX_WIDTH) && (int'(y_coord) < MAX_HEIGHT);
  assign wgt_we   = accept && (action == ACT_WEIGHT) &&
                    (int'(tap_col) < MAX_KERNEL) && (int'(tap_row) < MAX_KERNEL);
  assign pix_waddr = PAW'(y_coord) * PAW'(MAX_WIDTH) + PAW'(x_coord);
  assign wgt_waddr = WAW'(tap_row) * WAW'(MAX_KERNEL) + WAW'(tap_col);

  // Coordinates of the item in work
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_x <= x_coord;
      cmd_y <= y_coord;
    end
  end

  rkc_ram #(.DEPTH(PDEPTH), .DW(PIX_W), .AW(PAW)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata ({red_in, green_in, blue_in}),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  rkc_ram #(.DEPTH(WDEPTH), .DW(WGT_W), .AW(WAW)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (tap_weight),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  rkc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL),
    .WW(WW), .HW(HW), .KW(KW), .PAW(PAW), .WAW(WAW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .img_w     (img_w),
    .img_h     (img_h),
    .ksize     (ksize),
    .res_take  (res_take),
    .busy      (busy),
    .res_ready (res_ready),
    .mac_ctl   (mac_ctl),
    .pix_raddr (pix_raddr),
    .wgt_raddr (wgt_raddr)
  );

  rkc_mac #(.MAX_KERNEL(MAX_KERNEL)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .pix       (pix_rdata),
    .wgt       (wgt_rdata),
    .gain      (output_gain),
    .res_red   (res_red),
    .res_green (res_green),
    .res_blue  (res_blue)
  );

  // Output register
  assign res_take = res_ready && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_x     <= cmd_x;
      out_y     <= cmd_y;
      out_red   <= res_red;
      out_green <= res_green;
      out_blue  <= res_blue;
    end
  end

endmodule

@@ sim/tb_rgb_kernel_convolution_wrap.sv @@
// Self-checking testbench for the RGB kernel convolution block with toroidal wrap.
`timescale 1ns / 1ps

module tb_rgb_kernel_convolution_wrap;
  import rkc_pkg::*;

  localparam int MAXW         = DEF_MAX_WIDTH;
  localparam int MAXH         = DEF_MAX_HEIGHT;
  localparam int MAXK         = DEF_MAX_KERNEL;
  localparam int SETTLE_CYC   = 80;          // beyond the longest compute
  localparam int DRAIN_LIMIT  = 50000;
  localparam int RUN_LIMIT_NS = 16_000_000;
  localparam int MAX_PRINTS   = 40;

  // Action code with no function in the block
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURST} stall_mode_t;

  typedef struct packed {
    logic [ACT_W-1:0]        act;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic [CH_W-1:0]         r;
    logic [CH_W-1:0]         g;
    logic [CH_W-1:0]         b;
    logic [TAP_W-1:0]        tc;
    logic [TAP_W-1:0]        tr;
    logic signed [WGT_W-1:0] wt;
  } conv_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
  } filtered_pixel_t;

  // DUT signals
  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [ACT_W-1:0]        action;
  logic [COORD_W-1:0]      x_coord;
  logic [COORD_W-1:0]      y_coord;
  logic [CH_W-1:0]         red_in;
  logic [CH_W-1:0]         green_in;
  logic [CH_W-1:0]         blue_in;
  logic [TAP_W-1:0]        tap_col;
  logic [TAP_W-1:0]        tap_row;
  logic signed [WGT_W-1:0] tap_weight;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [COORD_W-1:0]      out_x;
  logic [COORD_W-1:0]      out_y;
  logic [CH_W-1:0]         out_red;
  logic [CH_W-1:0]         out_green;
  logic [CH_W-1:0]         out_blue;
  logic                    cfg_write;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  // Shadow frame, kernel and registers
  logic [PIX_W-1:0]        pix_mem [0:MAXW*MAXH-1];
  bit                      pix_set [0:MAXW*MAXH-1];
  logic signed [WGT_W-1:0] wgt_mem [0:MAXK*MAXK-1];
  bit                      wgt_set [0:MAXK*MAXK-1];
  logic [DIM_W-1:0]        width_reg  = RST_WIDTH;
  logic [DIM_W-1:0]        height_reg = RST_HEIGHT;
  logic [KSZ_W-1:0]        ksize_reg  = RST_KSIZE;
  logic [GAIN_W-1:0]       gain_reg   = RST_GAIN;

  filtered_pixel_t filtered_q[$];

  int err_cnt    = 0;
  int n_items    = 0;
  int n_computes = 0;
  int n_results  = 0;
  int n_settings = 0;
  int burst_left = 0;
  int hot_x      = 0;
  int hot_y      = 0;

  stall_mode_t rx_mode = RX_FREE;
  int          rx_left = 0;

  rgb_kernel_convolution_wrap u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .tap_col    (tap_col),
    .tap_row    (tap_row),
    .tap_weight (tap_weight),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int eff_ksize(logic [KSZ_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAXK) return MAXK;
    return int'(v);
  endfunction

  // Non-negative (base + tap - center) mod dim
  function automatic int wrap_coord(int base, int tap, int ctr, int dim);
    return ((base % dim) + (tap % dim) + dim - (ctr % dim)) % dim;
  endfunction

  // Q.12 sum times Q8.16 gain, truncated and clamped to a channel
  function automatic logic [CH_W-1:0] scale_sum(longint acc);
    longint prod;
    longint q;
    prod = acc * longint'({40'd0, gain_reg});
    if (prod <= 0) return '0;
    q = prod >>> Q_SHIFT;
    if (q > 255) return 8'd255;
    return q[CH_W-1:0];
  endfunction

  function automatic filtered_pixel_t convolve_at(logic [COORD_W-1:0] px,
                                                   logic [COORD_W-1:0] py);
    filtered_pixel_t res;
    int w, h, k, ctr, ix, iy;
    longint acc_r, acc_g, acc_b, wt;
    logic [PIX_W-1:0] p;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    k = eff_ksize(ksize_reg);
    ctr = k / 2;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int fy = 0; fy < k; fy++) begin
      iy = wrap_coord(int'(py), fy, ctr, h);
      for (int fx = 0; fx < k; fx++) begin
        ix = wrap_coord(int'(px), fx, ctr, w);
        p = pix_mem[iy * MAXW + ix];
        wt = longint'(wgt_mem[fy * MAXK + fx]);
        acc_r += longint'({56'd0, p[23:16]}) * wt;
        acc_g += longint'({56'd0, p[15:8]}) * wt;
        acc_b += longint'({56'd0, p[7:0]}) * wt;
      end
    end
    res.x = px;
    res.y = py;
    res.r = scale_sum(acc_r);
    res.g = scale_sum(acc_g);
    res.b = scale_sum(acc_b);
    return res;
  endfunction

  // Apply one accepted item to the shadow state
  function automatic void absorb_item(conv_item_t it);
    int addr;
    addr = int'(it.y) * MAXW + int'(it.x);
    case (it.act)
      ACT_PIXEL: begin
        pix_mem[addr] = {it.r, it.g, it.b};
        pix_set[addr] = 1'b1;
        n_items++;
      end
      ACT_WEIGHT: begin
        // taps outside the kernel are dropped
        if (int'(it.tc) < MAXK && int'(it.tr) < MAXK) begin
          wgt_mem[int'(it.tr) * MAXK + int'(it.tc)] = it.wt;
          wgt_set[int'(it.tr) * MAXK + int'(it.tc)] = 1'b1;
          n_items++;
        end
      end
      ACT_COMPUTE: begin
        filtered_q.push_back(convolve_at(it.x, it.y));
        n_items++;
        n_computes++;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [WGT_W-1:0] rand_weight();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: begin
        v = $urandom;
        return v[15:0];
      end
      default: begin
        // small taps keep sums away from the clamps
        v = $urandom_range(0, 2047);
        return v[15:0] - 16'sd1024;
      end
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return RST_GAIN;
      1: return GAIN_W'($urandom_range(0, 131072));
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(8192, 32768));
    endcase
  endfunction

  // Uniform (in frame or anywhere) if small, else mostly a window near a hot spot
  function automatic int pick_coord(int dim, int hot, bit in_frame);
    if (dim <= 32) return in_frame ? $urandom_range(0, dim - 1) : $urandom_range(0, 255);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 255);
    return (hot + $urandom_range(0, 9)) % 256;
  endfunction

  // Every field random, so unused fields toggle too
  function automatic conv_item_t noise_fields();
    conv_item_t it;
    it.act = ACT_W'($urandom_range(0, 3));
    it.x   = COORD_W'($urandom);
    it.y   = COORD_W'($urandom);
    it.r   = CH_W'($urandom);
    it.g   = CH_W'($urandom);
    it.b   = CH_W'($urandom);
    it.tc  = TAP_W'($urandom);
    it.tr  = TAP_W'($urandom);
    it.wt  = WGT_W'($urandom);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One item through the input handshake, then the sender's burst pacing
  task automatic send_item(input conv_item_t it);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= it.act;
    x_coord    <= it.x;
    y_coord    <= it.y;
    red_in     <= it.r;
    green_in   <= it.g;
    blue_in    <= it.b;
    tap_col    <= it.tc;
    tap_row    <= it.tr;
    tap_weight <= it.wt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
    end
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] px, py,
                            input logic [CH_W-1:0] r, g, b);
    conv_item_t it;
    it = noise_fields();
    it.act = ACT_PIXEL;
    it.x = px;
    it.y = py;
    it.r = r;
    it.g = g;
    it.b = b;
    send_item(it);
  endtask

  task automatic send_weight(input logic [TAP_W-1:0] tc, tr,
                             input logic signed [WGT_W-1:0] wt);
    conv_item_t it;
    it = noise_fields();
    it.act = ACT_WEIGHT;
    it.tc = tc;
    it.tr = tr;
    it.wt = wt;
    send_item(it);
  endtask

  // Fill any unwritten tap or neighbor first, then request the output pixel
  task automatic send_compute(input logic [COORD_W-1:0] px, py);
    conv_item_t it;
    int w, h, k, ctr, ix, iy;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    k = eff_ksize(ksize_reg);
    ctr = k / 2;
    for (int fy = 0; fy < k; fy++)
      for (int fx = 0; fx < k; fx++)
        if (!wgt_set[fy * MAXK + fx]) send_weight(TAP_W'(fx), TAP_W'(fy), rand_weight());
    for (int fy = 0; fy < k; fy++) begin
      iy = wrap_coord(int'(py), fy, ctr, h);
      for (int fx = 0; fx < k; fx++) begin
        ix = wrap_coord(int'(px), fx, ctr, w);
        if (!pix_set[iy * MAXW + ix])
          send_pixel(COORD_W'(ix), COORD_W'(iy),
                     rand_channel(), rand_channel(), rand_channel());
      end
    end
    it = noise_fields();
    it.act = ACT_COMPUTE;
    it.x = px;
    it.y = py;
    send_item(it);
  endtask

  task automatic send_unused();
    conv_item_t it;
    it = noise_fields();
    it.act = ACT_UNUSED;
    send_item(it);
  endtask

  // Hold the sender off until every pending pixel has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg  = data[DIM_W-1:0];
      REG_HEIGHT: height_reg = data[DIM_W-1:0];
      REG_KSIZE:  ksize_reg  = data[KSZ_W-1:0];
      REG_GAIN:   gain_reg   = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // New frame setting, written only once the block has gone quiet
  task automatic set_frame(input logic [CFG_W-1:0] wd, hd, kd, gd);
    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, hd);
    write_reg(REG_KSIZE, kd);
    write_reg(REG_GAIN, gd);
    case ($urandom_range(0, 2))
      0: hot_x = 0;
      1: hot_x = 250;
      default: hot_x = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 2))
      0: hot_y = 0;
      1: hot_y = 250;
      default: hot_y = $urandom_range(0, 255);
    endcase
    n_settings++;
  endtask

  // Random traffic on the current setting: mostly computes with valid operands
  task automatic run_phase(input int target);
    int start, pick, w, h;
    start = n_items;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    while (n_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_compute(COORD_W'(pick_coord(w, hot_x, 1'b0)),
                     COORD_W'(pick_coord(h, hot_y, 1'b0)));
      end else if (pick < 76) begin
        if ($urandom_range(0, 4) == 0)
          send_pixel(COORD_W'($urandom), COORD_W'($urandom),
                     rand_channel(), rand_channel(), rand_channel());
        else
          send_pixel(COORD_W'(pick_coord(w, hot_x, 1'b1)),
                     COORD_W'(pick_coord(h, hot_y, 1'b1)),
                     rand_channel(), rand_channel(), rand_channel());
      end else if (pick < 90) begin
        send_weight(TAP_W'($urandom_range(0, 7)), TAP_W'($urandom_range(0, 7)),
                    rand_weight());
      end else if (pick < 96) begin
        send_unused();
      end else begin
        wait_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setting: weight and pixel extremes, dropped taps, unused action,
  // computes that wrap over both frame edges
  task automatic test_directed_basics();
    send_weight(3'd0, 3'd0, 16'sh8000);
    send_weight(3'd6, 3'd6, 16'sh7FFF);
    send_weight(3'd7, 3'd2, 16'sh1234);
    send_weight(3'd3, 3'd7, 16'sh4321);
    send_weight(3'd1, 3'd1, 16'sh1000);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd128);
    send_unused();
    send_compute(8'd0, 8'd0);
    send_compute(8'd255, 8'd255);
  endtask

  // Small and lopsided frames, kernels larger than the frame, even sizes
  task automatic test_wrap_geometry();
    set_frame(24'd4, 24'd4, 24'd3, 24'd65536);
    run_phase(130);
    set_frame(24'd2, 24'd3, 24'd5, rand_gain());
    run_phase(130);
    set_frame(24'd1, 24'd1, 24'd7, 24'd65536);
    run_phase(130);
    set_frame(24'd3, 24'd256, 24'd6, rand_gain());
    run_phase(130);
    set_frame(24'd256, 24'd1, 24'd5, rand_gain());
    run_phase(130);
  endtask

  // Register values outside the usable range, plus bits above each field
  task automatic test_saturated_settings();
    set_frame(24'd0, 24'd0, 24'd0, 24'd65536);
    run_phase(130);
    set_frame(24'd511, 24'd511, 24'd7, 24'hFFFFFF);
    run_phase(130);
    set_frame(24'hABC12C, 24'h5A5101, 24'hFFFFF8, rand_gain());
    run_phase(130);
  endtask

  task automatic test_gain_range();
    set_frame(24'd5, 24'd7, 24'd3, 24'd0);
    run_phase(130);
    set_frame(24'd6, 24'd6, 24'd4, 24'hFFFFFF);
    run_phase(130);
    set_frame(24'd8, 24'd8, 24'd7, 24'd1);
    run_phase(130);
  endtask

  task automatic test_random_mix();
    logic [31:0] junk;
    logic [DIM_W-1:0] wd, hd;
    logic [KSZ_W-1:0] kd;
    for (int i = 0; i < 5; i++) begin
      wd = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 511))
                                       : DIM_W'($urandom_range(1, 16));
      hd = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 511))
                                       : DIM_W'($urandom_range(1, 16));
      kd = KSZ_W'($urandom_range(0, 7));
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      set_frame({junk[14:0], wd}, {junk[29:15], hd}, {junk[20:0], kd}, rand_gain());
      run_phase(100);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_filtered
    filtered_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", out_x, out_y));
      end else begin
        want = filtered_q.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_red !== want.r ||
            out_green !== want.g || out_blue !== want.b)
          report_mismatch($sformatf(
            "got (%0d,%0d) rgb %0d/%0d/%0d, want (%0d,%0d) rgb %0d/%0d/%0d",
            out_x, out_y, out_red, out_green, out_blue,
            want.x, want.y, want.r, want.g, want.b));
      end
    end
  end

  // Receiver stalls, switching between patterns
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= stall_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ((rx_left % 16) < 6);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int guard;
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_PIXEL;
    x_coord    = '0;
    y_coord    = '0;
    red_in     = '0;
    green_in   = '0;
    blue_in    = '0;
    tap_col    = '0;
    tap_row    = '0;
    tap_weight = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_WIDTH;
    cfg_data   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_wrap_geometry();
    test_saturated_settings();
    test_gain_range();
    test_random_mix();

    // Let the last computes come back
    @(negedge clk);
    in_valid <= 1'b0;
    for (guard = 0; guard < DRAIN_LIMIT && filtered_q.size() != 0; guard++)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (filtered_q.size() != 0)
      report_mismatch($sformatf("%0d filtered pixels never arrived", filtered_q.size()));

    $display("Covered %0d items over %0d frame settings: %0d computes, %0d pixels checked",
             n_items, n_settings + 1, n_computes, n_results);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d filtered pixels pending", filtered_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
